// ===== design/plsch_pkg.sv =====
// Package for the piecewise-linear schedule evaluator.
// Holds the widths, codes, state type and structs shared by all design files.
// Depends on nothing.
package plsch_pkg;

   localparam int MAX_SEGMENTS = 8;
   localparam int FRAC_BITS    = 16;

   localparam int TIME_W      = 32;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 4;
   localparam int HIT_W       = 3;
   localparam int ENTRY_W     = 3;
   localparam int REGION_W    = 2;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   localparam int IDX_W     = $clog2(MAX_SEGMENTS);
   localparam int ALPHA_W   = FRAC_BITS + 1;
   localparam int STEP_W    = $clog2(ALPHA_W + 1);
   localparam int DIFF_W    = VALUE_W + 1;
   localparam int SCALED_W  = DIFF_W + 2;
   localparam int SUM_W     = SCALED_W + 1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_BITS;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_POST_VALUE    = CSR_INDEX_W'(1);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   typedef enum logic [1:0] {
      REGION_POST   = 2'd0,
      REGION_BEFORE = 2'd1,
      REGION_LERP   = 2'd2,
      REGION_FLAT   = 2'd3
   } region_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0]         first_time;
      logic [TIME_W-1:0]         last_time;
      logic signed [VALUE_W-1:0] first_value;
      logic signed [VALUE_W-1:0] last_value;
   } seg_entry_type;

   typedef struct packed {
      logic start;
   } serial_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } serial_status_type;

endpackage

// ===== design/plsch_seg_store.sv =====
// Segment table of the schedule evaluator: one entry per slot.
// One write port and one registered read port. Uses plsch_pkg.
module plsch_seg_store (
   input  logic                    clock,
   input  logic                    we,
   input  logic [plsch_pkg::IDX_W-1:0] waddr,
   input  plsch_pkg::seg_entry_type    wdata,
   input  logic                    re,
   input  logic [plsch_pkg::IDX_W-1:0] raddr,
   output plsch_pkg::seg_entry_type    rdata
);
   import plsch_pkg::*;

   seg_entry_type mem [MAX_SEGMENTS];
   seg_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/plsch_divider.sv =====
// Radix-2 restoring divider that produces alpha one quotient bit per cycle.
// Computes (dividend << FRAC_BITS) / divisor for dividend <= divisor. Uses plsch_pkg.
module plsch_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  plsch_pkg::serial_ctrl_type    ctrl,
   input  logic [plsch_pkg::TIME_W-1:0]  dividend,
   input  logic [plsch_pkg::TIME_W-1:0]  divisor,
   output plsch_pkg::serial_status_type  status,
   output logic [plsch_pkg::ALPHA_W-1:0] quotient
);
   import plsch_pkg::*;

   logic [TIME_W-1:0]  rem_ff, rem_in;
   logic [TIME_W-1:0]  den_ff, den_in;
   logic [ALPHA_W-1:0] bits_ff, bits_in;
   logic [ALPHA_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [TIME_W:0]    trial;
   logic [TIME_W:0]    diff;

   // Since the quotient stays below 2^(FRAC_BITS+1), the partial remainder
   // above the quotient bits is dividend >> 1, and only dividend[0] remains
   // to be brought down ahead of the fraction zeros.
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, bits_ff[ALPHA_W-1]};
      diff    = trial - {1'b0, den_ff};
      if (ctrl.start) begin
         rem_in  = dividend >> 1;
         den_in  = divisor;
         bits_in = {dividend[0], {FRAC_BITS{1'b0}}};
         quo_in  = '0;
         step_in = STEP_W'(ALPHA_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[TIME_W]) begin
            rem_in = diff[TIME_W-1:0];
            quo_in = {quo_ff[ALPHA_W-2:0], 1'b1};
         end else begin
            rem_in = trial[TIME_W-1:0];
            quo_in = {quo_ff[ALPHA_W-2:0], 1'b0};
         end
         bits_in = {bits_ff[ALPHA_W-2:0], 1'b0};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ===== design/plsch_multiplier.sv =====
// Shift-add multiplier that takes one alpha bit per cycle, LSB first.
// Returns (alpha * |diff|) >> FRAC_BITS, truncated. Uses plsch_pkg.
module plsch_multiplier (
   input  logic                           clock,
   input  logic                           reset,
   input  plsch_pkg::serial_ctrl_type     ctrl,
   input  logic [plsch_pkg::ALPHA_W-1:0]  alpha,
   input  logic signed [plsch_pkg::DIFF_W-1:0] diff,
   output plsch_pkg::serial_status_type   status,
   output logic [plsch_pkg::SCALED_W-1:0] scaled
);
   import plsch_pkg::*;

   logic [DIFF_W-1:0]  mag_ff, mag_in;
   logic [DIFF_W:0]    hi_ff, hi_in;
   logic [ALPHA_W-1:0] lo_ff, lo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIFF_W+1:0]  acc;

   always_comb begin
      mag_in  = mag_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc     = {1'b0, hi_ff} + (lo_ff[0] ? {2'b00, mag_ff} : '0);
      if (ctrl.start) begin
         mag_in  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
         hi_in   = '0;
         lo_in   = alpha;
         step_in = STEP_W'(ALPHA_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in   = acc[DIFF_W+1:1];
         lo_in   = {acc[0], lo_ff[ALPHA_W-1:1]};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign scaled      = {hi_ff, lo_ff[ALPHA_W-1:FRAC_BITS]};

endmodule

// ===== design/piecewise_linear_schedule.sv =====
// Top level of the piecewise-linear schedule evaluator.
// Instantiates plsch_seg_store, plsch_divider and plsch_multiplier; uses plsch_pkg.
//
// A write item (opcode 0) stores one segment in its slot; it is taken without
// leaving the idle state and produces no result. An evaluate item (opcode 1) walks
// the segments in slot order, one table read and one compare per segment. When the
// deciding segment needs interpolation, alpha comes from a bit-serial divider and
// the product from a bit-serial shift-add multiplier, followed by an add and
// saturate step. One item is in work at a time; the next is taken while a finished
// result still waits in the output register. Slots are undefined until written,
// there is no clearing pass after reset, and configuration is to be written
// through the csr_ port only while the block is idle, which the block itself
// does not enforce.
module piecewise_linear_schedule (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_opcode,
   input  logic [plsch_pkg::ENTRY_W-1:0]        req_entry_index,
   input  logic [plsch_pkg::TIME_W-1:0]         req_entry_start_time,
   input  logic [plsch_pkg::TIME_W-1:0]         req_entry_end_time,
   input  logic signed [plsch_pkg::VALUE_W-1:0] req_entry_start_value,
   input  logic signed [plsch_pkg::VALUE_W-1:0] req_entry_end_value,
   input  logic [plsch_pkg::TIME_W-1:0]         req_query_time,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [plsch_pkg::VALUE_W-1:0] rsp_result_value,
   output logic [plsch_pkg::REGION_W-1:0]       rsp_region,
   output logic [plsch_pkg::HIT_W-1:0]          rsp_hit_segment,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [plsch_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [plsch_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import plsch_pkg::*;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          addr_ff, addr_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        seg_count_ff, seg_count_in;
   logic signed [VALUE_W-1:0] post_value_ff, post_value_in;
   logic [TIME_W-1:0]         time_ff, time_in;
   logic signed [VALUE_W-1:0] sv_ff, sv_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [VALUE_W-1:0] res_value_ff, res_value_in;
   region_type                res_region_ff, res_region_in;
   logic [IDX_W-1:0]          res_hit_ff, res_hit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   region_type                rsp_region_ff, rsp_region_in;
   logic [IDX_W-1:0]          rsp_hit_ff, rsp_hit_in;

   logic                      mem_we;
   logic                      mem_re;
   seg_entry_type             mem_wdata;
   seg_entry_type             entry;
   logic                      slot_ok;

   serial_ctrl_type           div_ctrl;
   serial_status_type         div_status;
   logic [ALPHA_W-1:0]        alpha;
   logic [TIME_W-1:0]         div_dividend;
   logic [TIME_W-1:0]         div_divisor;
   serial_ctrl_type           mul_ctrl;
   serial_status_type         mul_status;
   logic [SCALED_W-1:0]       scaled;

   logic [COUNT_W-1:0]        count_clamped;
   logic                      last_seg;
   logic                      out_free;
   logic signed [SUM_W-1:0]   sv_ext;
   logic signed [SUM_W-1:0]   prod_ext;
   logic signed [SUM_W-1:0]   sum;
   logic                      sum_fits;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // A write to a slot beyond the table is dropped.
   assign slot_ok = (32'(req_entry_index) < MAX_SEGMENTS);
   assign mem_we  = req_valid && req_ready && (req_opcode == OP_WRITE) && slot_ok;

   assign mem_wdata.first_time  = req_entry_start_time;
   assign mem_wdata.last_time   = req_entry_end_time;
   assign mem_wdata.first_value = req_entry_start_value;
   assign mem_wdata.last_value  = req_entry_end_value;

   plsch_seg_store u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (req_entry_index[IDX_W-1:0]),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (addr_ff),
      .rdata (entry)
   );

   // The divider sees the offset into the segment and its width straight from
   // the table read; it latches both on its start pulse.
   assign div_dividend = time_ff - entry.first_time;
   assign div_divisor  = entry.last_time - entry.first_time;

   plsch_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (alpha)
   );

   plsch_multiplier u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mul_ctrl),
      .alpha  (alpha),
      .diff   (diff_ff),
      .status (mul_status),
      .scaled (scaled)
   );

   // A segment count above the table size uses the whole table.
   assign count_clamped = (seg_count_ff > COUNT_W'(MAX_SEGMENTS)) ?
                          COUNT_W'(MAX_SEGMENTS) : seg_count_ff;
   assign last_seg = ((COUNT_W'(addr_ff) + COUNT_W'(1)) == count_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // The multiplier works on the magnitude, so truncation toward zero is a plain
   // drop of the fraction; the sign of the difference picks add or subtract.
   assign sv_ext   = {{(SUM_W-VALUE_W){sv_ff[VALUE_W-1]}}, sv_ff};
   assign prod_ext = {1'b0, scaled};
   assign sum      = diff_ff[DIFF_W-1] ? (sv_ext - prod_ext) : (sv_ext + prod_ext);
   assign sum_fits = (&sum[SUM_W-1:VALUE_W-1]) || !(|sum[SUM_W-1:VALUE_W-1]);

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      time_in       = time_ff;
      sv_in         = sv_ff;
      diff_in       = diff_ff;
      res_value_in  = res_value_ff;
      res_region_in = res_region_ff;
      res_hit_in    = res_hit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_region_in = rsp_region_ff;
      rsp_hit_in    = rsp_hit_ff;
      seg_count_in  = seg_count_ff;
      post_value_in = post_value_ff;
      mem_re        = 1'b0;
      div_ctrl.start = 1'b0;
      mul_ctrl.start = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SEGMENT_COUNT: seg_count_in  = csr_wdata[COUNT_W-1:0];
            CSR_POST_VALUE:    post_value_in = csr_wdata[VALUE_W-1:0];
            default:           ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_opcode == OP_EVAL)) begin
               time_in  = req_query_time;
               count_in = count_clamped;
               addr_in  = '0;
               if (count_clamped == '0) begin
                  res_value_in  = post_value_ff;
                  res_region_in = REGION_POST;
                  res_hit_in    = '0;
                  state_in      = ST_FIN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if ((addr_ff == '0) && (time_ff <= entry.first_time)) begin
               // At or before the first start: hold the first start value.
               res_value_in  = entry.first_value;
               res_region_in = REGION_BEFORE;
               res_hit_in    = '0;
               state_in      = ST_FIN;
            end else if (time_ff <= entry.last_time) begin
               res_hit_in = addr_ff;
               if (entry.last_time <= entry.first_time) begin
                  // Zero or inverted width: the end value stands.
                  res_value_in  = entry.last_value;
                  res_region_in = REGION_FLAT;
                  state_in      = ST_FIN;
               end else begin
                  res_region_in = REGION_LERP;
                  sv_in         = entry.first_value;
                  diff_in       = {entry.last_value[VALUE_W-1], entry.last_value} -
                                  {entry.first_value[VALUE_W-1], entry.first_value};
                  if (time_ff < entry.first_time) begin
                     // Time in a gap before this segment: alpha is zero.
                     res_value_in = entry.first_value;
                     state_in     = ST_FIN;
                  end else begin
                     div_ctrl.start = 1'b1;
                     state_in       = ST_DIV;
                  end
               end
            end else if (last_seg) begin
               res_value_in  = post_value_ff;
               res_region_in = REGION_POST;
               res_hit_in    = '0;
               state_in      = ST_FIN;
            end else begin
               addr_in  = addr_ff + IDX_W'(1);
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            // The offset never exceeds the width here, so alpha is already
            // within [0, 1.0] and needs no clamp.
            if (div_status.done) begin
               mul_ctrl.start = 1'b1;
               state_in       = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_status.done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (sum_fits) begin
               res_value_in = sum[VALUE_W-1:0];
            end else begin
               res_value_in = sum[SUM_W-1] ? VALUE_MIN : VALUE_MAX;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_region_in = res_region_ff;
               rsp_hit_in    = res_hit_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         seg_count_ff  <= '0;
         post_value_ff <= '0;
         addr_ff       <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         seg_count_ff  <= seg_count_in;
         post_value_ff <= post_value_in;
         addr_ff       <= addr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff       <= time_in;
      sv_ff         <= sv_in;
      diff_ff       <= diff_in;
      res_value_ff  <= res_value_in;
      res_region_ff <= res_region_in;
      res_hit_ff    <= res_hit_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_region_ff <= rsp_region_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_region       = rsp_region_ff;
   assign rsp_hit_segment  = HIT_W'(rsp_hit_ff);

`ifndef SYNTHESIS
   // The search never reads past the last segment in use.
   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (COUNT_W'(addr_ff) < count_ff))
      else $error("segment search ran past the segment count");

   // Alpha never exceeds one, since the offset stays within the width.
   a_alpha_bound: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (alpha <= ALPHA_ONE))
      else $error("alpha above one");

   // The divider only finishes while the sequencer waits for it.
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // While the sequencer waits on the multiplier, the multiplier is at work.
   a_mul_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (mul_status.busy || mul_status.done))
      else $error("multiply state with an idle multiplier");

   // Post value and before-first results carry segment zero.
   a_hit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_region == REGION_POST) || (rsp_region == REGION_BEFORE)))
      |-> (rsp_hit_segment == '0))
      else $error("nonzero hit segment outside a segment region");
`endif

endmodule
